### hw/rtl/lkv_pkg.sv
package lkv_pkg;

    // Store geometry
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W      = IDX_W;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // Register and field widths
    localparam int CAP_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int CAP_RESET  = 10;

    typedef enum logic {
        OP_GET    = 1'b0,
        OP_UPDATE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_FREE  = 2'd1,
        ST_EVICT = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

endpackage

### hw/rtl/lkv_req_if.sv
interface lkv_req_if;
    import lkv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;

    modport source (output valid, output opcode, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input write_value,
                    output ready);
endinterface

### hw/rtl/lkv_rsp_if.sv
interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

### hw/rtl/lkv_cfg_if.sv
interface lkv_cfg_if;
    import lkv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Each request beat is a get or an update of one key and yields exactly one
// response beat (status and read value). Keys and values live in one
// synchronous single-port-read memory; valid bits, recency ranks and the fill
// count sit in flip-flops. After accepting a request, the block reads every
// memory entry in turn, comparing keys and tracking the oldest entry and the
// first free slot, waits in a drain state for the last read to land, and then
// in a decide state updates ranks, writes the memory and loads the response
// register. It takes no new request until it is idle again. The response
// register decouples the output: a new request is accepted while a response
// still waits; the decide cycle stalls only if the previous response has not
// been taken. The capacity register (reset 10, zero acts as one, values above
// 16 act as 16) is always ready to take a beat and should be written only
// while the block is idle.
module lru_key_value_cache (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkv_cfg_if.sink    i_cfg,
    lkv_req_if.sink    i_req,
    lkv_rsp_if.source  o_rsp
);
    import lkv_pkg::*;

    // Control and bookkeeping
    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_capacity;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [AGE_W-1:0]      r_age [ENTRIES];
    logic [AGE_W-1:0]      n_age [ENTRIES];
    logic [CNT_W-1:0]      r_count, n_count;

    // Latched request
    t_opcode               r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    // Memory and read walk
    t_entry                r_mem [ENTRIES];
    t_entry                r_q_data;
    logic [IDX_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_q_idx;
    logic                  r_q_vld;

    // Scan trackers
    logic                  r_hit_f, r_old_f, r_free_f;
    logic [IDX_W-1:0]      r_hit_idx, r_old_idx, r_free_idx;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic [AGE_W-1:0]      r_old_age;

    // Response register
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [VALUE_BITS-1:0] r_out_rdata;

    // Decide-cycle signals
    logic                  out_free;
    logic                  decide_fire;
    logic                  req_fire;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    t_entry                mem_wdata;
    t_status               dec_status;
    logic [VALUE_BITS-1:0] dec_rdata;
    logic [CNT_W-1:0]      eff_cap;
    logic [AGE_W-1:0]      hit_age;
    logic                  evict;
    logic [IDX_W-1:0]      slot;
    logic [ENTRIES-1:0]    kept_valid;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign decide_fire = (r_state == S_DECIDE) && out_free;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rdata;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(CAP_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_capacity <= i_cfg.data;
        end
    end

    // Clamp capacity into 1 .. ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_capacity) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_capacity);
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_addr == IDX_W'(ENTRIES - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Latch the request beat
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op  <= t_opcode'(i_req.opcode);
            r_key <= i_req.lookup_key;
            r_val <= i_req.write_value;
        end
    end

    // Walk the read address and tag the returning data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= (r_state == S_SCAN);
        end
        r_q_idx <= r_addr;
        if (req_fire) begin
            r_addr <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Key/value memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q_data <= r_mem[r_addr];
    end

    // Track hit, oldest entry and first free slot as entries stream by
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || req_fire) begin
            r_hit_f  <= 1'b0;
            r_old_f  <= 1'b0;
            r_free_f <= 1'b0;
        end else if (r_q_vld) begin
            if (r_valid[r_q_idx] && r_q_data.key == r_key && !r_hit_f) begin
                r_hit_f   <= 1'b1;
                r_hit_idx <= r_q_idx;
                r_hit_val <= r_q_data.value;
            end
            if (r_valid[r_q_idx] && (!r_old_f || r_age[r_q_idx] > r_old_age)) begin
                r_old_f   <= 1'b1;
                r_old_idx <= r_q_idx;
                r_old_age <= r_age[r_q_idx];
            end
            if (!r_valid[r_q_idx] && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_q_idx;
            end
        end
    end

    assign hit_age = r_age[r_hit_idx];
    assign evict   = (r_count >= eff_cap) || !r_free_f;
    assign slot    = evict ? (r_old_f ? r_old_idx : '0) : r_free_idx;

    // Decide: status, rank update, memory write
    always_comb begin
        n_valid    = r_valid;
        n_count    = r_count;
        n_age      = r_age;
        mem_we     = 1'b0;
        mem_waddr  = r_hit_idx;
        mem_wdata  = '{key: r_key, value: r_val};
        dec_status = ST_MISS;
        dec_rdata  = '0;
        kept_valid = r_valid;
        if (r_hit_f) begin
            // Touch: younger entries age by one, hit becomes most recent
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && r_age[i] < hit_age) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            n_age[r_hit_idx] = '0;
            dec_status = ST_HIT;
            if (r_op == OP_GET) begin
                dec_rdata = r_hit_val;
            end else begin
                mem_we = 1'b1;
            end
        end else if (r_op == OP_UPDATE) begin
            // Insert: drop the victim if needed, age the rest, fill the slot
            if (evict) begin
                kept_valid[slot] = 1'b0;
                dec_status = ST_EVICT;
            end else begin
                n_count    = r_count + CNT_W'(1);
                dec_status = ST_FREE;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (kept_valid[i]) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            n_age[slot]   = '0;
            n_valid       = kept_valid;
            n_valid[slot] = 1'b1;
            mem_we        = 1'b1;
            mem_waddr     = slot;
        end
        if (!decide_fire) begin
            mem_we = 1'b0;
        end
    end

    // Valid bits, ranks and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (decide_fire) begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
        if (decide_fire) begin
            r_age <= n_age;
        end
    end

    // Response register: load on decide, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (decide_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (decide_fire) begin
            r_out_status <= dec_status;
            r_out_rdata  <= dec_rdata;
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("fill count differs from number of valid entries");

    a_state_stable_outside_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !decide_fire |=> $stable(r_valid) && $stable(r_count))
        else $error("valid bits or count changed outside the decide cycle");

    a_get_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (decide_fire && r_op == OP_GET) |=> $stable(r_valid))
        else $error("get request changed valid bits");

    a_hit_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_hit_f) |-> r_valid[r_hit_idx])
        else $error("hit recorded on an invalid entry");
`endif

endmodule
